@@ rtl/ccle_pkg.sv @@
`timescale 1ns / 1ps
package ccle_pkg;
	localparam int BackupDepthDef = 256;
	localparam int AddrW = 30;
	localparam int DataW = 32;
	localparam logic [1:0] FuncExec = 2'd0;
	localparam logic [1:0] FuncPass = 2'd1;
	localparam logic [1:0] FuncRestore = 2'd2;
	localparam logic [1:0] KindWrite = 2'd0;
	localparam logic [1:0] KindMulti = 2'd1;
	localparam logic [1:0] KindOne = 2'd2;
	localparam logic [1:0] KindOther = 2'd3;
	localparam logic [1:0] SizeByte = 2'd0;
	localparam logic [1:0] SizeHalf = 2'd1;
	localparam logic [1:0] SizeWord = 2'd2;
	localparam logic RegRamLow = 1'b0;
	localparam logic RegRamHigh = 1'b1;

	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic [1:0] size;
		logic [DataW-1:0] value;
	} entry_t;

	function automatic logic [DataW-1:0] size_mask(input logic [1:0] sz);
		case (sz)
			SizeByte: size_mask = 32'h0000_00FF;
			SizeHalf: size_mask = 32'h0000_FFFF;
			default: size_mask = 32'hFFFF_FFFF;
		endcase
	endfunction
endpackage

@@ rtl/ccle_cell.sv @@
`timescale 1ns / 1ps
module ccle_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic clear,
	input  logic load,
	input  ccle_pkg::entry_t load_entry,
	input  logic shift,
	input  ccle_pkg::entry_t prev_entry,
	input  logic prev_valid,
	input  logic [ccle_pkg::AddrW-1:0] key,
	output ccle_pkg::entry_t entry,
	output logic valid,
	output logic hit
);
	import ccle_pkg::*;
	entry_t entry_q;
	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_entry;
		end else if (shift) begin
			entry_q <= prev_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;
	assign hit = valid_q && (entry_q.addr == key);
endmodule

@@ rtl/cheat_code_line_executor_top.sv @@
// One code line or command per start request, one result strobe per request, taken
// unconditionally by the receiver. Busy is high while a request is in the EXEC and DONE states.
// The backup table is a row of cells searched in parallel against the target address.
// Entries still to be restored sit at the front of the row in recording order, entries already
// restored sit behind them. A new entry is inserted right after the entries still to be
// restored, with the restored ones moving up by one cell. A restore reads the front cell and
// rotates it to the back of the entries still to be restored.
// Configuration writes are taken at any time and should only be issued while busy is low.
`timescale 1ns / 1ps
module cheat_code_line_executor_top #(
	parameter int BACKUP_DEPTH = ccle_pkg::BackupDepthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] func,
	input  logic [31:0] code_word_hi,
	input  logic [31:0] code_word_lo,
	input  logic [31:0] mem_value,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [29:0] cfg_data,
	output logic done,
	output logic write_valid,
	output logic [29:0] write_address,
	output logic [1:0] write_size,
	output logic [31:0] write_data,
	output logic backup_recorded,
	output logic backup_full,
	output logic line_skipped,
	output logic [1:0] line_kind,
	output logic restore_last
);
	import ccle_pkg::*;
	localparam int CntW = $clog2(BACKUP_DEPTH + 1);

	typedef enum logic [1:0] {IDLE, EXEC, DONE} state_t;
	state_t state_q;

	logic [29:0] ram_low_q, ram_high_q;
	logic [11:0] skip_q;
	logic [CntW-1:0] count_q, pend_q;
	logic [1:0] func_q;
	logic [31:0] hi_q, lo_q, mem_q;

	entry_t cell_entry [BACKUP_DEPTH];
	logic [BACKUP_DEPTH-1:0] cell_valid, cell_hit, cell_load, cell_shift;
	logic cell_clear, rs;
	entry_t new_entry, load_src;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != IDLE);

	logic [3:0] t;
	logic [1:0] kind, sz, cop;
	logic [29:0] tgt_hi, tgt_lo, addr;
	logic [31:0] m, want, cur, cval, ca;
	logic in_win, cmp_ok, c8, found;
	logic [30:0] end_addr;
	logic [11:0] n;

	always_comb begin
		t = hi_q[31:28];
		if (t <= 4'd2) kind = KindWrite;
		else if (t == 4'hE) kind = KindMulti;
		else if (t == 4'hD) kind = KindOne;
		else kind = KindOther;
		tgt_hi = 30'({2'b0, hi_q[27:0]} + ram_low_q);
		tgt_lo = 30'({2'b0, lo_q[27:0]} + ram_low_q);
		if (t == 4'd1) sz = SizeHalf;
		else if (t == 4'd2) sz = SizeWord;
		else if (lo_q[31:16] != 16'd0) sz = SizeWord;
		else if (lo_q[15:8] != 8'd0) sz = SizeHalf;
		else sz = SizeByte;
		m = size_mask(sz);
		want = lo_q & m;
		cur = mem_q & m;
		end_addr = {1'b0, tgt_hi} + 31'(32'd1 << sz);
		if (kind == KindMulti) begin
			addr = tgt_lo;
			c8 = (hi_q[31:24] == 8'hE1);
			cval = c8 ? {24'd0, hi_q[7:0]} : {16'd0, hi_q[15:0]};
			cop = lo_q[29:28];
			n = c8 ? {4'd0, hi_q[23:16]} : hi_q[27:16];
		end else begin
			addr = tgt_hi;
			c8 = (lo_q[31:28] == 4'd2);
			cval = c8 ? {24'd0, lo_q[7:0]} : {16'd0, lo_q[15:0]};
			cop = lo_q[21:20];
			n = 12'd1;
		end
		ca = mem_q & (c8 ? 32'h0000_00FF : 32'h0000_FFFF);
		in_win = (addr >= ram_low_q) && (addr < ram_high_q);
		case (cop)
			2'd0: cmp_ok = (ca == cval);
			2'd1: cmp_ok = (ca != cval);
			2'd2: cmp_ok = (ca < cval);
			default: cmp_ok = (ca > cval);
		endcase
		found = |cell_hit;
	end

	logic do_write;
	assign do_write = (func_q == FuncExec) && (skip_q == 12'd0) && (kind == KindWrite)
		&& (tgt_hi >= ram_low_q) && (end_addr <= {1'b0, ram_high_q}) && (cur != want);
	assign new_entry = '{addr: tgt_hi, size: sz, value: cur};

	logic ld;
	assign ld = (state_q == EXEC) && do_write && !found && (count_q < CntW'(BACKUP_DEPTH));
	assign rs = (state_q == EXEC) && (func_q == FuncRestore) && (pend_q != '0);
	assign cell_clear = (state_q == EXEC) && (func_q == FuncRestore) && (pend_q <= CntW'(1));
	assign load_src = ld ? new_entry : cell_entry[0];

	genvar g;
	generate
		for (g = 0; g < BACKUP_DEPTH; g++) begin : g_cell
			assign cell_load[g] = (ld && (pend_q == CntW'(g)))
				|| (rs && (pend_q == CntW'(g + 1)));
			assign cell_shift[g] = (ld && (CntW'(g) > pend_q) && (CntW'(g) <= count_q))
				|| (rs && (CntW'(g + 1) < pend_q));
			ccle_cell u_cell (
				.clk(clk), .arst_n(arst_n), .clear(cell_clear), .load(cell_load[g]),
				.load_entry(load_src), .shift(cell_shift[g]),
				.prev_entry(ld ? cell_entry[(g+BACKUP_DEPTH-1)%BACKUP_DEPTH]
					: cell_entry[(g+1)%BACKUP_DEPTH]),
				.prev_valid(ld ? cell_valid[(g+BACKUP_DEPTH-1)%BACKUP_DEPTH]
					: cell_valid[(g+1)%BACKUP_DEPTH]),
				.key(tgt_hi), .entry(cell_entry[g]), .valid(cell_valid[g]), .hit(cell_hit[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_low_q <= 30'h0880_0000;
			ram_high_q <= 30'h0A00_0000;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == RegRamLow) ram_low_q <= cfg_data;
			else ram_high_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			skip_q <= '0;
			count_q <= '0;
			pend_q <= '0;
			done <= 1'b0;
			write_valid <= 1'b0;
			write_address <= '0;
			write_size <= '0;
			write_data <= '0;
			backup_recorded <= 1'b0;
			backup_full <= 1'b0;
			line_skipped <= 1'b0;
			line_kind <= KindOther;
			restore_last <= 1'b0;
			func_q <= FuncExec;
			hi_q <= '0;
			lo_q <= '0;
			mem_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				IDLE: begin
					if (start) begin
						func_q <= func;
						hi_q <= code_word_hi;
						lo_q <= code_word_lo;
						mem_q <= mem_value;
						state_q <= EXEC;
					end
				end
				EXEC: begin
					write_valid <= 1'b0;
					write_address <= '0;
					write_size <= '0;
					write_data <= '0;
					backup_recorded <= 1'b0;
					backup_full <= 1'b0;
					line_skipped <= 1'b0;
					line_kind <= KindOther;
					restore_last <= 1'b0;
					case (func_q)
						FuncExec: begin
							line_kind <= kind;
							if (skip_q != 12'd0) begin
								skip_q <= skip_q - 12'd1;
								line_skipped <= 1'b1;
							end else if (kind == KindWrite) begin
								if (do_write) begin
									write_valid <= 1'b1;
									write_address <= tgt_hi;
									write_size <= sz;
									write_data <= want;
									if (!found) begin
										if (ld) begin
											backup_recorded <= 1'b1;
											count_q <= count_q + CntW'(1);
											pend_q <= pend_q + CntW'(1);
										end else begin
											backup_full <= 1'b1;
										end
									end
								end
							end else if (kind == KindMulti || kind == KindOne) begin
								if (!(in_win && cmp_ok)) skip_q <= n;
							end
						end
						FuncPass: skip_q <= '0;
						FuncRestore: begin
							if (pend_q != '0) begin
								write_valid <= 1'b1;
								write_address <= cell_entry[0].addr;
								write_size <= cell_entry[0].size;
								write_data <= cell_entry[0].value & size_mask(cell_entry[0].size);
								pend_q <= pend_q - CntW'(1);
							end
							if (pend_q <= CntW'(1)) begin
								restore_last <= 1'b1;
								count_q <= '0;
								pend_q <= '0;
							end
						end
						default: ;
					endcase
					done <= 1'b1;
					state_q <= DONE;
				end
				DONE: state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import ccle_pkg::*;

	localparam int Depth = BackupDepthDef;
	localparam int CycleLimit = 400000;
	localparam logic [29:0] Mask30 = 30'h3FFF_FFFF;

	typedef struct packed {
		logic wv;
		logic [29:0] wa;
		logic [1:0] ws;
		logic [31:0] wd;
		logic rec;
		logic full;
		logic skipped;
		logic [1:0] kind;
		logic last;
	} line_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] func = FuncExec;
	logic [31:0] code_word_hi = '0;
	logic [31:0] code_word_lo = '0;
	logic [31:0] mem_value = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = RegRamLow;
	logic [29:0] cfg_data = '0;
	logic done;
	logic write_valid;
	logic [29:0] write_address;
	logic [1:0] write_size;
	logic [31:0] write_data;
	logic backup_recorded;
	logic backup_full;
	logic line_skipped;
	logic [1:0] line_kind;
	logic restore_last;

	cheat_code_line_executor_top dut (.*);

	logic [29:0] ram_lo = 30'h0880_0000;
	logic [29:0] ram_hi = 30'h0A00_0000;
	logic [11:0] skip_left = '0;
	logic [29:0] bk_addr [Depth];
	logic [1:0] bk_size [Depth];
	logic [31:0] bk_val [Depth];
	int bk_count = 0;
	int rst_idx = 0;

	line_result_t pending_results [$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;

	initial forever #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("cheat_code_line_executor_top verification failed");
			$finish;
		end
	end

	function automatic logic [31:0] mask_of(input logic [1:0] sz);
		return sz == SizeByte ? 32'hFF : sz == SizeHalf ? 32'hFFFF : 32'hFFFF_FFFF;
	endfunction

	function automatic logic cmp_op(input logic [1:0] op, input logic [31:0] a, b);
		case (op)
			2'd0: return a == b;
			2'd1: return a != b;
			2'd2: return a < b;
			default: return a > b;
		endcase
	endfunction

	function automatic logic [29:0] target_of(input logic [31:0] w);
		logic [31:0] s;
		s = {4'h0, w[27:0]} + {2'b00, ram_lo};
		return s[29:0];
	endfunction

	function automatic logic in_window(input logic [29:0] a, input int bytes);
		return a >= ram_lo && (longint'(a) + bytes <= longint'(ram_hi));
	endfunction

	function automatic line_result_t execute_line(input logic [1:0] f,
			input logic [31:0] hi, lo, mem);
		line_result_t r;
		logic [3:0] t;
		logic [29:0] addr;
		logic [1:0] sz;
		logic [31:0] m, want, cur, val;
		logic is8, found, ok;
		r = '0;
		r.kind = KindOther;
		if (f == FuncExec) begin
			t = hi[31:28];
			r.kind = t <= 4'd2 ? KindWrite : t == 4'hE ? KindMulti :
				t == 4'hD ? KindOne : KindOther;
			if (skip_left > 0) begin
				skip_left--;
				r.skipped = 1'b1;
			end else if (r.kind == KindWrite) begin
				addr = target_of(hi);
				sz = t == 4'd1 ? SizeHalf : t == 4'd2 ? SizeWord :
					(lo & 32'hFFFF_0000) != 0 ? SizeWord :
					(lo & 32'hFF00) != 0 ? SizeHalf : SizeByte;
				m = mask_of(sz);
				want = lo & m;
				cur = mem & m;
				if (in_window(addr, 1 << sz) && cur != want) begin
					found = 1'b0;
					for (int i = 0; i < bk_count; i++)
						if (bk_addr[i] == addr) found = 1'b1;
					if (!found) begin
						if (bk_count >= Depth) begin
							r.full = 1'b1;
						end else begin
							bk_addr[bk_count] = addr;
							bk_size[bk_count] = sz;
							bk_val[bk_count] = cur;
							bk_count++;
							r.rec = 1'b1;
						end
					end
					r.wv = 1'b1;
					r.wa = addr;
					r.ws = sz;
					r.wd = want;
				end
			end else if (r.kind == KindMulti) begin
				is8 = hi[31:24] == 8'hE1;
				val = is8 ? (hi & 32'hFF) : (hi & 32'hFFFF);
				addr = target_of(lo);
				cur = mem & (is8 ? 32'hFF : 32'hFFFF);
				ok = in_window(addr, 1) && cmp_op(lo[29:28], cur, val);
				if (!ok) skip_left = is8 ? {4'h0, hi[23:16]} : hi[27:16];
			end else if (r.kind == KindOne) begin
				addr = target_of(hi);
				is8 = lo[31:28] == 4'd2;
				val = is8 ? (lo & 32'hFF) : (lo & 32'hFFFF);
				cur = mem & (is8 ? 32'hFF : 32'hFFFF);
				ok = in_window(addr, 1) && cmp_op(lo[21:20], cur, val);
				if (!ok) skip_left = 12'd1;
			end
		end else if (f == FuncPass) begin
			skip_left = '0;
		end else if (f == FuncRestore) begin
			if (rst_idx < bk_count) begin
				r.wv = 1'b1;
				r.wa = bk_addr[rst_idx];
				r.ws = bk_size[rst_idx];
				r.wd = bk_val[rst_idx] & mask_of(bk_size[rst_idx]);
				rst_idx++;
			end
			if (rst_idx >= bk_count) begin
				r.last = 1'b1;
				bk_count = 0;
				rst_idx = 0;
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp, act);
		if (exp !== act) begin
			$error("%s: expected %h, got %h", name, exp, act);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		line_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result strobe with no request outstanding");
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("write_valid", e.wv, write_valid);
				check_field("write_address", e.wa, write_address);
				check_field("write_size", e.ws, write_size);
				check_field("write_data", e.wd, write_data);
				check_field("backup_recorded", e.rec, backup_recorded);
				check_field("backup_full", e.full, backup_full);
				check_field("line_skipped", e.skipped, line_skipped);
				check_field("line_kind", e.kind, line_kind);
				check_field("restore_last", e.last, restore_last);
			end
		end
	end

	task automatic send_request(input logic [1:0] f, input logic [31:0] hi, lo, mem);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		code_word_hi <= hi;
		code_word_lo <= lo;
		mem_value <= mem;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(execute_line(f, hi, lo, mem));
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [29:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == RegRamLow) ram_lo = data;
		else ram_hi = data;
		@(posedge clk);
	endtask

	task automatic test_directed;
		write_reg(RegRamLow, 30'h0880_0000);
		write_reg(RegRamHigh, 30'h0A00_0000);
		send_request(FuncRestore, '0, '0, '0);
		send_request(FuncExec, 32'h0000_0010, 32'h0000_00AB, 32'h0000_0000);
		send_request(FuncExec, 32'h0000_0014, 32'h0000_1234, 32'h0000_0000);
		send_request(FuncExec, 32'h0000_0018, 32'hDEAD_BEEF, 32'h0000_0000);
		send_request(FuncExec, 32'h1000_0020, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(FuncExec, 32'h2000_0024, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(FuncExec, 32'h0000_0010, 32'h0000_00CD, 32'h0000_00AB);
		send_request(FuncExec, 32'h2000_0024, 32'h1111_1111, 32'h1111_1111);
		send_request(FuncExec, 32'h0FFF_FFFF, 32'h0000_0055, 32'h0000_0000);
		send_request(FuncExec, 32'hE002_0055, 32'h0000_0010, 32'h0000_0055);
		send_request(FuncExec, 32'hE002_0055, 32'h1000_0010, 32'h0000_0055);
		send_request(FuncExec, 32'h0000_0030, 32'h0000_0001, 32'h0000_0000);
		send_request(FuncExec, 32'hD000_0030, 32'h0000_0001, 32'h0000_0000);
		send_request(FuncExec, 32'hE103_0077, 32'h2000_0040, 32'h0000_0010);
		send_request(FuncPass, '0, '0, '0);
		send_request(FuncExec, 32'hD000_0040, 32'h2030_0005, 32'h0000_0009);
		send_request(FuncExec, 32'hD0FF_FFFF, 32'h0000_0000, 32'h0000_0000);
		send_request(FuncExec, 32'h5000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(FuncPass, '0, '0, '0);
		repeat (8) send_request(FuncRestore, '0, '0, '0);
		drain();
	endtask

	task automatic test_backup_full;
		for (int i = 0; i < Depth + 4; i++)
			send_request(FuncExec, 32'h2000_0000 | (i * 4), 32'hFFFF_FFFF, 32'h0);
		send_request(FuncExec, 32'h1000_0000, 32'h0000_1234, 32'h0);
		for (int i = 0; i < Depth + 2; i++)
			send_request(FuncRestore, '0, '0, '0);
		drain();
	endtask

	task automatic send_random_line;
		logic [31:0] hi, lo, mem, off;
		int pick;
		off = $urandom_range(0, 3) == 0 ? $urandom() : {$urandom_range(0, 47), 2'b00};
		pick = $urandom_range(0, 99);
		mem = $urandom();
		if (pick < 55) begin
			hi = {2'b00, 2'($urandom_range(0, 2)), off[27:0]};
			if (hi[29:28] == 2'd3) hi[29:28] = 2'd0;
			case ($urandom_range(0, 2))
				0: lo = $urandom_range(0, 255);
				1: lo = $urandom_range(0, 65535);
				default: lo = $urandom();
			endcase
			if ($urandom_range(0, 2) == 0) mem = lo;
			send_request(FuncExec, hi, lo, mem);
		end else if (pick < 65) begin
			hi = {4'hE, 4'($urandom_range(0, 2)), 8'($urandom_range(0, 3)), 16'($urandom())};
			lo = {4'($urandom()), off[27:0]};
			if ($urandom_range(0, 1)) mem = hi & 32'hFFFF;
			send_request(FuncExec, hi, lo, mem);
		end else if (pick < 75) begin
			hi = {4'hD, off[27:0]};
			lo = $urandom();
			if ($urandom_range(0, 1)) lo[31:28] = 4'd2;
			if ($urandom_range(0, 1)) mem = lo & 32'hFFFF;
			send_request(FuncExec, hi, lo, mem);
		end else if (pick < 81) begin
			send_request(FuncPass, $urandom(), $urandom(), $urandom());
		end else if (pick < 90) begin
			send_request(FuncRestore, $urandom(), $urandom(), $urandom());
		end else begin
			send_request(2'($urandom()), $urandom(), $urandom(), $urandom());
		end
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) send_random_line();
		drain();
	endtask

	task automatic test_window_settings;
		write_reg(RegRamLow, 30'h0);
		write_reg(RegRamHigh, Mask30);
		test_random(120);
		write_reg(RegRamLow, 30'h3FFF_FF00);
		write_reg(RegRamHigh, Mask30);
		test_random(120);
		write_reg(RegRamLow, 30'h0000_0100);
		write_reg(RegRamHigh, 30'h0000_0100);
		test_random(60);
		write_reg(RegRamLow, 30'h0880_0000);
		write_reg(RegRamHigh, 30'h0880_0082);
		test_random(100);
		write_reg(RegRamLow, 30'h0880_0000);
		write_reg(RegRamHigh, 30'h0A00_0000);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 9;
		test_directed();
		test_backup_full();
		test_random(100);
		send_idle_pct = 60;
		test_window_settings();
		test_random(100);
		send_idle_pct = 0;
		test_random(200);
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("cheat_code_line_executor_top verification clean");
		end else begin
			$display("cheat_code_line_executor_top verification failed");
		end
		$finish;
	end
endmodule
